// ----- design/slps_pkg.sv -----
package slps_pkg;

   // Width of the hold and pulse countdowns.
   localparam int TIME_BITS = 16;
   localparam logic [32:0] TIME_MAX = 33'((64'd1 << TIME_BITS) - 64'd1);

   localparam int MS_BITS    = 16;
   localparam int CSR_IDX_BITS = 3;
   localparam int PCT_BITS   = 7;
   localparam int HUE_BITS   = 9;

   typedef logic [TIME_BITS-1:0] time_type;
   typedef logic [MS_BITS-1:0]   ms_type;
   typedef logic [PCT_BITS-1:0]  pct_type;
   typedef logic [HUE_BITS-1:0]  hue_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_SLOW_BLINK   = 3'd0,
      CSR_FAST_BLINK   = 3'd1,
      CSR_LEARN_BLINK  = 3'd2,
      CSR_SUCCESS_HOLD = 3'd3,
      CSR_FAILED_HOLD  = 3'd4,
      CSR_IR_PULSE     = 3'd5,
      CSR_BRIGHTNESS   = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      EVT_NONE     = 3'd0,
      EVT_PROGRESS = 3'd1,
      EVT_SUCCESS  = 3'd2,
      EVT_FAILED   = 3'd3,
      EVT_IDLE     = 3'd4
   } learn_event_type;

   typedef enum logic [1:0] {
      MODE_NONE     = 2'd0,
      MODE_PROGRESS = 2'd1,
      MODE_SUCCESS  = 2'd2,
      MODE_FAILED   = 2'd3
   } learn_mode_type;

   typedef enum logic [2:0] {
      VS_BOOTING       = 3'd0,
      VS_COMMISSIONING = 3'd1,
      VS_READY         = 3'd2,
      VS_LEARNING      = 3'd3,
      VS_SUCCESS       = 3'd4,
      VS_FAILED        = 3'd5,
      VS_IR_PULSE      = 3'd6
   } visual_state_type;

   localparam ms_type RST_SLOW_BLINK   = 16'd500;
   localparam ms_type RST_FAST_BLINK   = 16'd200;
   localparam ms_type RST_LEARN_BLINK  = 16'd150;
   localparam ms_type RST_SUCCESS_HOLD = 16'd900;
   localparam ms_type RST_FAILED_HOLD  = 16'd2000;
   localparam ms_type RST_IR_PULSE     = 16'd120;
   localparam pct_type RST_BRIGHTNESS  = 7'd10;

   localparam hue_type HUE_RED    = 9'd0;
   localparam hue_type HUE_YELLOW = 9'd50;
   localparam hue_type HUE_GREEN  = 9'd120;
   localparam hue_type HUE_BLUE   = 9'd240;
   localparam pct_type PCT_FULL   = 7'd100;
   localparam pct_type PCT_ZERO   = 7'd0;

   // Bring a 16-bit millisecond setting into the countdown range, saturating.
   function automatic time_type time_limit(ms_type v);
      logic [32:0] wide;
      wide = 33'(v);
      if (wide > TIME_MAX) begin
         return TIME_MAX[TIME_BITS-1:0];
      end
      return wide[TIME_BITS-1:0];
   endfunction

endpackage

// ----- design/slps_if.sv -----
interface slps_req_if;
   logic       valid;
   logic       ready;
   logic       booted;
   logic       commission_window;
   logic [2:0] learning_event;
   logic       ir_tx_notify;

   modport source (output valid, booted, commission_window, learning_event,
                   ir_tx_notify, input ready);
   modport sink (input valid, booted, commission_window, learning_event,
                 ir_tx_notify, output ready);
endinterface

interface slps_rsp_if;
   logic       valid;
   logic       ready;
   logic       led_on;
   logic [8:0] hue;
   logic [6:0] saturation;
   logic [6:0] brightness;
   logic [2:0] visual_state;

   modport source (output valid, led_on, hue, saturation, brightness, visual_state,
                   input ready);
   modport sink (input valid, led_on, hue, saturation, brightness, visual_state,
                 output ready);
endinterface

interface slps_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- design/status_led_pattern_sequencer_top.sv -----
// Status LED sequencer: each item on req_chan is one millisecond tick and yields exactly one
// LED frame on rsp_chan. An item is registered on acceptance and its frame is then computed
// into the output register when that register is free, so one item is taken every cycle
// while the output side keeps up; a stalled output holds back the input
// register only once both stages are full. Settings on csr_chan are always ready, take effect
// on the next tick and should only be written while no tick is in flight.
module status_led_pattern_sequencer_top (
   input logic       clock,
   input logic       reset,
   slps_req_if.sink  req_chan,
   slps_rsp_if.source rsp_chan,
   slps_csr_if.sink  csr_chan
);
   import slps_pkg::*;

   // Configuration registers
   ms_type  slow_blink_ff, fast_blink_ff, learn_blink_ff;
   ms_type  success_hold_ff, failed_hold_ff, ir_pulse_ff;
   pct_type brightness_ff;

   // Input register
   logic       s1_valid_ff;
   logic       s1_ready_ff, s1_comm_ff, s1_irtx_ff;
   logic [2:0] s1_event_ff;

   // Sequencer state
   learn_mode_type mode_ff, mode_in;
   time_type       learn_left_ff, learn_left_in;
   time_type       ir_left_ff, ir_left_in;

   // Output register
   logic             out_valid_ff;
   logic             out_on_ff, out_on_in;
   hue_type          out_hue_ff, out_hue_in;
   pct_type          out_sat_ff, out_sat_in;
   pct_type          out_bright_ff, out_bright_in;
   visual_state_type out_vs_ff, out_vs_in;

   logic advance;
   logic slow_on, fast_on, learn_on;
   learn_mode_type mode_evt;
   time_type       learn_evt, ir_evt;

   assign advance        = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         slow_blink_ff   <= RST_SLOW_BLINK;
         fast_blink_ff   <= RST_FAST_BLINK;
         learn_blink_ff  <= RST_LEARN_BLINK;
         success_hold_ff <= RST_SUCCESS_HOLD;
         failed_hold_ff  <= RST_FAILED_HOLD;
         ir_pulse_ff     <= RST_IR_PULSE;
         brightness_ff   <= RST_BRIGHTNESS;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_SLOW_BLINK:   slow_blink_ff   <= csr_chan.data;
            CSR_FAST_BLINK:   fast_blink_ff   <= csr_chan.data;
            CSR_LEARN_BLINK:  learn_blink_ff  <= csr_chan.data;
            CSR_SUCCESS_HOLD: success_hold_ff <= csr_chan.data;
            CSR_FAILED_HOLD:  failed_hold_ff  <= csr_chan.data;
            CSR_IR_PULSE:     ir_pulse_ff     <= csr_chan.data;
            CSR_BRIGHTNESS:   brightness_ff   <= csr_chan.data[PCT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_ready_ff <= req_chan.booted;
         s1_comm_ff  <= req_chan.commission_window;
         s1_event_ff <= req_chan.learning_event;
         s1_irtx_ff  <= req_chan.ir_tx_notify;
      end
   end

   slps_blinker u_slow (
      .clock(clock), .reset(reset), .advance(advance),
      .half_period(slow_blink_ff), .phase_on(slow_on));
   slps_blinker u_fast (
      .clock(clock), .reset(reset), .advance(advance),
      .half_period(fast_blink_ff), .phase_on(fast_on));
   slps_blinker u_learn (
      .clock(clock), .reset(reset), .advance(advance),
      .half_period(learn_blink_ff), .phase_on(learn_on));

   // Apply the tick's events.
   always_comb begin
      mode_evt  = mode_ff;
      learn_evt = learn_left_ff;
      case (s1_event_ff)
         EVT_PROGRESS: begin
            mode_evt  = MODE_PROGRESS;
            learn_evt = '0;
         end
         EVT_SUCCESS: begin
            mode_evt  = MODE_SUCCESS;
            learn_evt = time_limit(success_hold_ff);
         end
         EVT_FAILED: begin
            mode_evt  = MODE_FAILED;
            learn_evt = time_limit(failed_hold_ff);
         end
         EVT_IDLE: begin
            if (mode_ff == MODE_PROGRESS) begin
               mode_evt  = MODE_NONE;
               learn_evt = '0;
            end
         end
         default: ;
      endcase
      ir_evt = s1_irtx_ff ? time_limit(ir_pulse_ff) : ir_left_ff;
   end

   // Expire finished holds, resolve the visual state and build the frame.
   always_comb begin
      mode_in = mode_evt;
      if ((mode_evt == MODE_SUCCESS || mode_evt == MODE_FAILED) && learn_evt == '0) begin
         mode_in = MODE_NONE;
      end
      learn_left_in = (learn_evt != '0) ? learn_evt - 1'b1 : '0;
      ir_left_in    = (ir_evt != '0) ? ir_evt - 1'b1 : '0;

      if (mode_in == MODE_PROGRESS)      out_vs_in = VS_LEARNING;
      else if (mode_in == MODE_SUCCESS)  out_vs_in = VS_SUCCESS;
      else if (mode_in == MODE_FAILED)   out_vs_in = VS_FAILED;
      else if (ir_evt != '0)             out_vs_in = VS_IR_PULSE;
      else if (!s1_ready_ff)             out_vs_in = VS_BOOTING;
      else if (s1_comm_ff)               out_vs_in = VS_COMMISSIONING;
      else                               out_vs_in = VS_READY;

      out_sat_in = PCT_FULL;
      case (out_vs_in)
         VS_BOOTING: begin
            out_on_in  = slow_on;
            out_hue_in = HUE_BLUE;
         end
         VS_COMMISSIONING: begin
            out_on_in  = fast_on;
            out_hue_in = HUE_BLUE;
         end
         VS_READY: begin
            out_on_in  = 1'b1;
            out_hue_in = HUE_GREEN;
         end
         VS_LEARNING: begin
            out_on_in  = learn_on;
            out_hue_in = HUE_YELLOW;
         end
         VS_SUCCESS: begin
            out_on_in  = learn_on;
            out_hue_in = HUE_GREEN;
         end
         VS_FAILED: begin
            out_on_in  = learn_on;
            out_hue_in = HUE_RED;
         end
         default: begin
            out_on_in  = 1'b1;
            out_hue_in = HUE_RED;
            out_sat_in = PCT_ZERO;
         end
      endcase

      out_bright_in = (brightness_ff > PCT_FULL) ? PCT_FULL : brightness_ff;
      if (out_bright_in == PCT_ZERO) begin
         out_on_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_NONE;
         learn_left_ff <= '0;
         ir_left_ff    <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (advance) begin
            mode_ff       <= mode_in;
            learn_left_ff <= learn_left_in;
            ir_left_ff    <= ir_left_in;
            out_valid_ff  <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_on_ff     <= out_on_in;
         out_hue_ff    <= out_hue_in;
         out_sat_ff    <= out_sat_in;
         out_bright_ff <= out_bright_in;
         out_vs_ff     <= out_vs_in;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.led_on       = out_on_ff;
   assign rsp_chan.hue          = out_hue_ff;
   assign rsp_chan.saturation   = out_sat_ff;
   assign rsp_chan.brightness   = out_bright_ff;
   assign rsp_chan.visual_state = out_vs_ff;

`ifndef SYNTHESIS
   // Only a success or failed effect may have hold time left.
   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_NONE || mode_ff == MODE_PROGRESS) |-> (learn_left_ff == '0))
      else $error("hold time left without a timed learning effect");

   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_bright_ff == PCT_ZERO) |-> !out_on_ff)
      else $error("LED lit at zero brightness");

   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_vs_ff == VS_IR_PULSE) |-> (out_sat_ff == PCT_ZERO && out_on_ff ==
      (out_bright_ff != PCT_ZERO)))
      else $error("IR pulse frame is not steady white");

   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_event_ff)))
      else $error("stalled item lost from the input register");
`endif

endmodule

// ----- design/slps_blinker.sv -----
module slps_blinker (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  slps_pkg::ms_type    half_period,
   output logic                phase_on
);
   import slps_pkg::*;

   ms_type count_ff, count_in, count_inc;
   logic   phase_ff, phase_in;

   assign count_inc = count_ff + 16'd1;

   always_comb begin
      count_in = count_ff;
      phase_in = phase_ff;
      if (advance) begin
         if (half_period == '0) begin
            count_in = '0;
            phase_in = 1'b0;
         end else if (count_inc >= half_period) begin
            // Also catches a half period lowered below the running count.
            count_in = '0;
            phase_in = ~phase_ff;
         end else begin
            count_in = count_inc;
         end
      end
   end

   assign phase_on = (half_period == '0) || !phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         phase_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         phase_ff <= phase_in;
      end
   end

endmodule
